FILE: hw/rtl/bvir_pkg.sv
`timescale 1ns / 1ps

package bvir_pkg;

	// Width and reset value of the capacity register
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_SET    = 2'd2,
		ACT_GET    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What a cell does with its word each cycle
	typedef enum logic [1:0] {
		OP_HOLD       = 2'd0,
		OP_LOAD       = 2'd1,
		OP_FROM_LOWER = 2'd2,
		OP_FROM_UPPER = 2'd3
	} cell_op_t;

	// Command broadcast to every cell; only set for actions that succeed
	typedef struct packed {
		logic ins;
		logic rem;
		logic wr;
	} cell_cmd_t;

endpackage

FILE: hw/rtl/bvir_cell.sv
`timescale 1ns / 1ps

module bvir_cell
	import bvir_pkg::*;
#(
	parameter int IDX       = 0,
	parameter int POS_W     = 4,
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  cell_cmd_t            cmd,
	input  logic [POS_W-1:0]     pos,
	input  logic [WORD_BITS-1:0] new_word,
	input  logic [WORD_BITS-1:0] lower_word,
	input  logic [WORD_BITS-1:0] upper_word,
	output logic [WORD_BITS-1:0] word
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	logic [WORD_BITS-1:0] word_q;
	cell_op_t             op;

	// Insert: load at the position, shift up above it.
	// Remove: shift down from the position on. Write: load at the position.
	always_comb begin
		op = OP_HOLD;
		if (cmd.ins) begin
			if (MY_POS == pos) begin
				op = OP_LOAD;
			end else if (MY_POS > pos) begin
				op = OP_FROM_LOWER;
			end
		end else if (cmd.rem) begin
			if (MY_POS >= pos) begin
				op = OP_FROM_UPPER;
			end
		end else if (cmd.wr) begin
			if (MY_POS == pos) begin
				op = OP_LOAD;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_HOLD:       word_q <= word_q;
			OP_LOAD:       word_q <= new_word;
			OP_FROM_LOWER: word_q <= lower_word;
			OP_FROM_UPPER: word_q <= upper_word;
			default:       word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

FILE: hw/rtl/bounded_vector_insert_remove_core.sv
`timescale 1ns / 1ps
// Latency: a result is valid the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while out_ready does not stall the result; insert
// and remove shift every cell of the chain in parallel, so no action takes longer.
// Reset: clears the entry count and output valid, and sets capacity to 16.
// Entry words are not cleared; positions at or above the count are never read.

module bounded_vector_insert_remove_core
	import bvir_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write channel: capacity
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CAP_W-1:0]             cfg_data,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic [$clog2(DEPTH)-1:0]     position,
	input  logic [WORD_BITS-1:0]         value,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [WORD_BITS-1:0]         read_value,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic                         is_full,
	output logic                         is_empty
);

	localparam int POS_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	// common width for count, position and capacity compares
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	logic [CAP_W-1:0]     capacity_q;
	logic [CNT_W-1:0]     cnt_q;

	logic                 out_valid_q;
	status_t              status_q;
	logic [WORD_BITS-1:0] read_value_q;
	logic [CNT_W-1:0]     count_q;
	logic                 is_full_q;
	logic                 is_empty_q;

	logic                 accept;
	action_t              act;
	logic [CMP_W-1:0]     cap_w;
	logic [CMP_W-1:0]     cap_eff;
	logic [CMP_W-1:0]     cnt_w;
	logic [CMP_W-1:0]     pos_w;
	logic [CMP_W-1:0]     cnt_next_w;
	logic                 full_now;
	status_t              st;
	cell_cmd_t            cmd;
	logic [CNT_W-1:0]     cnt_next;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] sel_word;

	logic [WORD_BITS-1:0] chain [DEPTH];

	// Capacity is taken at any time; the user writes it only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// Take a new transaction whenever the result register is free or drains now.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign act      = action_t'(action);

	// Saturate capacity at the chain length; this also covers the chain-full case.
	assign cap_w    = CMP_W'(capacity_q);
	assign cap_eff  = (cap_w > DEPTH_C) ? DEPTH_C : cap_w;
	assign cnt_w    = CMP_W'(cnt_q);
	assign pos_w    = CMP_W'(position);
	assign full_now = (cnt_w >= cap_eff);

	// Decide status and the cell command; a refused action leaves the list alone.
	always_comb begin
		st       = ST_DONE;
		cmd      = '0;
		cnt_next = cnt_q;
		unique case (act)
			ACT_INSERT: begin
				if (pos_w > cnt_w) begin
					st = ST_RANGE;
				end else if (full_now) begin
					st = ST_FULL;
				end else begin
					cmd.ins  = accept;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			ACT_REMOVE, ACT_SET, ACT_GET: begin
				if (pos_w >= cnt_w) begin
					st = ST_RANGE;
				end else if (act == ACT_REMOVE) begin
					cmd.rem  = accept;
					cnt_next = cnt_q - CNT_W'(1);
				end else if (act == ACT_SET) begin
					cmd.wr = accept;
				end
			end
			default: st = ST_DONE;
		endcase
	end

	assign cnt_next_w = CMP_W'(cnt_next);

	// Pick the word at the requested position; cells are independent lanes.
	always_comb begin
		sel_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (POS_W'(i) == position) begin
				sel_word = sel_word | chain[i];
			end
		end
	end

	// Return data only for a read that succeeds.
	assign rd_word = (act == ACT_GET && st == ST_DONE) ? sel_word : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_next;
		end
	end

	// Chain of cells: each cell sees its lower and upper neighbor.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WORD_BITS-1:0] lower_w;
		logic [WORD_BITS-1:0] upper_w;

		if (g == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_lower
			assign lower_w = chain[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign upper_w = '0;
		end else begin : g_upper
			assign upper_w = chain[g+1];
		end

		bvir_cell #(
			.IDX       (g),
			.POS_W     (POS_W),
			.WORD_BITS (WORD_BITS)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (position),
			.new_word   (value),
			.lower_word (lower_w),
			.upper_word (upper_w),
			.word       (chain[g])
		);
	end

	// Output register: hold the result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= st;
			read_value_q <= rd_word;
			count_q      <= cnt_next;
			is_full_q    <= (cnt_next_w >= cap_eff);
			is_empty_q   <= (cnt_next == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_q;
	assign is_full    = is_full_q;
	assign is_empty   = is_empty_q;

endmodule
